>>> rtl/cmpwm_pkg.sv
package cmpwm_pkg;

  localparam int unsigned IdW     = 11;
  localparam int unsigned LenW    = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned SpeedW  = 9;
  localparam int unsigned MagW    = 7;
  localparam int unsigned ProdW   = MagW + DutyW;
  localparam int unsigned RecipW  = 13;
  localparam int unsigned ScaledW = ProdW + RecipW;

  // Tuning command identifiers
  localparam logic [IdW-1:0] IdSetAddress = 11'h300;
  localparam logic [IdW-1:0] IdMotorDir   = 11'h302;
  localparam logic [IdW-1:0] IdMaxDuty    = 11'h305;
  localparam logic [IdW-1:0] IdMinDuty    = 11'h306;
  localparam logic [IdW-1:0] IdSave       = 11'h307;
  localparam logic [IdW-1:0] IdTelemetry  = 11'h308;

  localparam logic [AddrW-1:0] Broadcast     = 16'hFFFF;
  localparam logic [ByteW-1:0] BroadcastHigh = 8'hFF;

  localparam logic [AddrW-1:0] AddrReset    = 16'h0500;
  localparam logic [DutyW-1:0] MaxDutyReset = 8'd255;
  localparam logic [DutyW-1:0] MinDutyReset = 8'd30;

  // Minimum frame lengths
  localparam logic [LenW-1:0] LenDrive = 4'd8;
  localparam logic [LenW-1:0] LenShort = 4'd2;
  localparam logic [LenW-1:0] LenValue = 4'd3;

  localparam logic [MagW-1:0] MagLimit = 7'd100;

  // floor(x / 100) == (x * 5243) >> 19 for every x up to 100 * 255
  localparam logic [RecipW-1:0] Recip100   = 13'd5243;
  localparam int unsigned       RecipShift = 19;

  typedef struct packed {
    logic [IdW-1:0]   frame_id;
    logic [LenW-1:0]  frame_len;
    logic [ByteW-1:0] byte_zero;
    logic [ByteW-1:0] byte_one;
    logic [ByteW-1:0] byte_two;
    logic [ByteW-1:0] up_level;
    logic [ByteW-1:0] down_level;
  } frame_t;

  typedef struct packed {
    logic [ProdW-1:0] product;
    logic [DutyW-1:0] min_duty;
    logic [DutyW-1:0] max_duty;
    logic             up;
    logic             down;
  } duty_op_t;

  typedef struct packed {
    logic             telemetry_valid;
    logic [AddrW-1:0] telemetry_address;
    logic             telemetry_inverted;
    logic [DutyW-1:0] telemetry_max;
    logic [DutyW-1:0] telemetry_min;
    logic             save_request;
  } report_t;

endpackage

>>> rtl/cmpwm_frame_if.sv
interface cmpwm_frame_if;
  logic                          valid;
  logic                          ready;
  logic [cmpwm_pkg::IdW-1:0]     frame_id;
  logic [cmpwm_pkg::LenW-1:0]    frame_len;
  logic [cmpwm_pkg::ByteW-1:0]   byte_zero;
  logic [cmpwm_pkg::ByteW-1:0]   byte_one;
  logic [cmpwm_pkg::ByteW-1:0]   byte_two;
  logic [cmpwm_pkg::ByteW-1:0]   up_level;
  logic [cmpwm_pkg::ByteW-1:0]   down_level;

  modport source (
    output valid, frame_id, frame_len, byte_zero, byte_one, byte_two, up_level, down_level,
    input  ready
  );
  modport sink (
    input  valid, frame_id, frame_len, byte_zero, byte_one, byte_two, up_level, down_level,
    output ready
  );
endinterface

>>> rtl/cmpwm_result_if.sv
interface cmpwm_result_if;
  logic                          valid;
  logic                          ready;
  logic [cmpwm_pkg::DutyW-1:0]   up_duty;
  logic [cmpwm_pkg::DutyW-1:0]   down_duty;
  logic                          telemetry_valid;
  logic [cmpwm_pkg::AddrW-1:0]   telemetry_address;
  logic                          telemetry_inverted;
  logic [cmpwm_pkg::DutyW-1:0]   telemetry_max;
  logic [cmpwm_pkg::DutyW-1:0]   telemetry_min;
  logic                          save_request;

  modport source (
    output valid, up_duty, down_duty, telemetry_valid, telemetry_address,
           telemetry_inverted, telemetry_max, telemetry_min, save_request,
    input  ready
  );
  modport sink (
    input  valid, up_duty, down_duty, telemetry_valid, telemetry_address,
           telemetry_inverted, telemetry_max, telemetry_min, save_request,
    output ready
  );
endinterface

>>> rtl/cmpwm_duty.sv
module cmpwm_duty (
  input  cmpwm_pkg::duty_op_t          op_i,
  output logic [cmpwm_pkg::DutyW-1:0]  up_duty_o,
  output logic [cmpwm_pkg::DutyW-1:0]  down_duty_o
);

  logic [cmpwm_pkg::ScaledW-1:0] scaled;
  logic [cmpwm_pkg::DutyW-1:0]   quot;
  logic [cmpwm_pkg::DutyW:0]     sum;
  logic [cmpwm_pkg::DutyW-1:0]   duty;

  always_comb begin
    // divide by 100 through the reciprocal
    scaled = cmpwm_pkg::ScaledW'(op_i.product) * cmpwm_pkg::ScaledW'(cmpwm_pkg::Recip100);
    quot   = scaled[cmpwm_pkg::RecipShift +: cmpwm_pkg::DutyW];
    sum    = {1'b0, op_i.min_duty} + {1'b0, quot};
    if (op_i.min_duty >= op_i.max_duty) begin
      duty = op_i.max_duty;
    end else if (sum > {1'b0, op_i.max_duty}) begin
      duty = op_i.max_duty;
    end else begin
      duty = sum[cmpwm_pkg::DutyW-1:0];
    end
    up_duty_o   = op_i.up   ? duty : '0;
    down_duty_o = op_i.down ? duty : '0;
  end

endmodule

>>> rtl/can_commanded_motor_pwm_unit.sv
// A frame is held in the input, duty operand and output registers in turn.
// Throughput: one frame per cycle while the output is not stalled; the tuning state
// is updated as a frame leaves the input register; the next frame decodes against it.
// Each of the three stages holds while the stage after it is full and stalled.
// Reset (rst_ni low, asynchronous) empties all stages and loads address 0x500,
// no inversion, max duty 255, min duty 30 and zero speed.
module can_commanded_motor_pwm_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  cmpwm_frame_if.sink    frame_i,
  cmpwm_result_if.source result_o
);

  // Pipeline control
  logic s0_valid_q, s1_valid_q, s2_valid_q;
  logic s0_ready, s1_ready, s2_ready, s0_move;

  assign s2_ready = !s2_valid_q || result_o.ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s0_ready = !s0_valid_q || s1_ready;
  assign s0_move  = s0_valid_q && s1_ready;
  assign frame_i.ready = s0_ready;

  // Tuning and speed state
  logic [cmpwm_pkg::AddrW-1:0]  node_address_q, node_address_d;
  logic                         inverted_q, inverted_d;
  logic [cmpwm_pkg::DutyW-1:0]  max_duty_q, max_duty_d;
  logic [cmpwm_pkg::DutyW-1:0]  min_duty_q, min_duty_d;
  logic signed [cmpwm_pkg::SpeedW-1:0] speed_q, speed_d;

  // Stage payloads
  cmpwm_pkg::frame_t   frame_q;
  cmpwm_pkg::duty_op_t op_d, op_q;
  cmpwm_pkg::report_t  rep_d, rep_q, rep_out_q;
  logic [cmpwm_pkg::DutyW-1:0] up_duty, down_duty, up_duty_q, down_duty_q;

  // Decode
  logic [cmpwm_pkg::AddrW-1:0]  target;
  logic                         matched, len_short, len_value, len_drive;
  logic                         telem, save;
  logic signed [cmpwm_pkg::SpeedW-1:0] s_eff;
  logic [cmpwm_pkg::DutyW-1:0]  s_abs, duty_range;
  logic [cmpwm_pkg::MagW-1:0]   mag;

  always_comb begin
    target    = {frame_q.byte_zero, frame_q.byte_one};
    matched   = (target == node_address_q) || (target == cmpwm_pkg::Broadcast);
    len_short = frame_q.frame_len >= cmpwm_pkg::LenShort;
    len_value = frame_q.frame_len >= cmpwm_pkg::LenValue;
    len_drive = frame_q.frame_len >= cmpwm_pkg::LenDrive;

    node_address_d = node_address_q;
    inverted_d     = inverted_q;
    max_duty_d     = max_duty_q;
    min_duty_d     = min_duty_q;
    speed_d        = speed_q;
    telem          = 1'b0;
    save           = 1'b0;

    // a drive match wins over tuning decode
    if (cmpwm_pkg::AddrW'(frame_q.frame_id) == node_address_q) begin
      if (len_drive) begin
        speed_d = $signed({1'b0, frame_q.up_level}) - $signed({1'b0, frame_q.down_level});
      end
    end else begin
      case (frame_q.frame_id)
        cmpwm_pkg::IdSetAddress: begin
          if (len_short && (target == node_address_q ||
                            frame_q.byte_zero == cmpwm_pkg::BroadcastHigh)) begin
            node_address_d = target;
          end
        end
        cmpwm_pkg::IdMotorDir: begin
          if (len_value && matched) inverted_d = (frame_q.byte_two != '0);
        end
        cmpwm_pkg::IdMaxDuty: begin
          if (len_value && matched) max_duty_d = frame_q.byte_two;
        end
        cmpwm_pkg::IdMinDuty: begin
          if (len_value && matched) min_duty_d = frame_q.byte_two;
        end
        cmpwm_pkg::IdSave: begin
          if (len_short && matched) save = 1'b1;
        end
        cmpwm_pkg::IdTelemetry: begin
          if (len_short && matched) telem = 1'b1;
        end
        default: ;
      endcase
    end

    // speed to clamped magnitude, using the state after this frame
    s_eff = inverted_d ? -speed_d : speed_d;
    s_abs = s_eff[cmpwm_pkg::SpeedW-1] ? cmpwm_pkg::DutyW'(-s_eff)
                                        : s_eff[cmpwm_pkg::DutyW-1:0];
    mag   = (s_abs > {1'b0, cmpwm_pkg::MagLimit}) ? cmpwm_pkg::MagLimit
                                                   : s_abs[cmpwm_pkg::MagW-1:0];
    duty_range = max_duty_d - min_duty_d;

    op_d.product  = cmpwm_pkg::ProdW'(mag) * cmpwm_pkg::ProdW'(duty_range);
    op_d.min_duty = min_duty_d;
    op_d.max_duty = max_duty_d;
    op_d.up       = !s_eff[cmpwm_pkg::SpeedW-1] && (s_eff != '0);
    op_d.down     = s_eff[cmpwm_pkg::SpeedW-1];

    rep_d.telemetry_valid    = telem;
    rep_d.telemetry_address  = telem ? node_address_d : '0;
    rep_d.telemetry_inverted = telem && inverted_d;
    rep_d.telemetry_max      = telem ? max_duty_d : '0;
    rep_d.telemetry_min      = telem ? min_duty_d : '0;
    rep_d.save_request       = save;
  end

  cmpwm_duty u_duty (
    .op_i        (op_q),
    .up_duty_o   (up_duty),
    .down_duty_o (down_duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q     <= 1'b0;
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      node_address_q <= cmpwm_pkg::AddrReset;
      inverted_q     <= 1'b0;
      max_duty_q     <= cmpwm_pkg::MaxDutyReset;
      min_duty_q     <= cmpwm_pkg::MinDutyReset;
      speed_q        <= '0;
    end else begin
      if (s0_ready) s0_valid_q <= frame_i.valid;
      if (s1_ready) s1_valid_q <= s0_valid_q;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      // commit state as the frame advances
      if (s0_move) begin
        node_address_q <= node_address_d;
        inverted_q     <= inverted_d;
        max_duty_q     <= max_duty_d;
        min_duty_q     <= min_duty_d;
        speed_q        <= speed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && frame_i.valid) begin
      frame_q.frame_id   <= frame_i.frame_id;
      frame_q.frame_len  <= frame_i.frame_len;
      frame_q.byte_zero  <= frame_i.byte_zero;
      frame_q.byte_one   <= frame_i.byte_one;
      frame_q.byte_two   <= frame_i.byte_two;
      frame_q.up_level   <= frame_i.up_level;
      frame_q.down_level <= frame_i.down_level;
    end
    if (s0_move) begin
      op_q  <= op_d;
      rep_q <= rep_d;
    end
    if (s2_ready && s1_valid_q) begin
      up_duty_q   <= up_duty;
      down_duty_q <= down_duty;
      rep_out_q   <= rep_q;
    end
  end

  assign result_o.valid              = s2_valid_q;
  assign result_o.up_duty            = up_duty_q;
  assign result_o.down_duty          = down_duty_q;
  assign result_o.telemetry_valid    = rep_out_q.telemetry_valid;
  assign result_o.telemetry_address  = rep_out_q.telemetry_address;
  assign result_o.telemetry_inverted = rep_out_q.telemetry_inverted;
  assign result_o.telemetry_max      = rep_out_q.telemetry_max;
  assign result_o.telemetry_min      = rep_out_q.telemetry_min;
  assign result_o.save_request       = rep_out_q.save_request;

  a_state_holds_without_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s0_move |=> $stable(node_address_q) && $stable(inverted_q) && $stable(max_duty_q)
                 && $stable(min_duty_q) && $stable(speed_q))
    else $error("tuning state changed with no frame leaving the input stage");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (up_duty_q == '0 || down_duty_q == '0))
    else $error("both drive duties nonzero");

  a_mid_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(op_q))
    else $error("duty stage lost its item under stall");

  a_telemetry_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !rep_out_q.telemetry_valid |->
      rep_out_q.telemetry_address == '0 && rep_out_q.telemetry_max == '0
      && rep_out_q.telemetry_min == '0 && !rep_out_q.telemetry_inverted)
    else $error("telemetry fields nonzero without telemetry");

  a_accept_when_output_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s0_valid_q |-> frame_i.ready)
    else $error("input not ready while input stage is empty");

endmodule
